[hw/rtl/scs1a_pkg.sv]
// ----------------------------------------------------------------------------
// scs1a_pkg
// Types, scancode constants and key tables for the set-1 scancode decoder.
// ----------------------------------------------------------------------------
package scs1a_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned OutDataW = 16;

  // scancodes with special handling
  localparam logic [CodeW-1:0] SC_PREFIX_E0   = 8'hE0;
  localparam logic [CodeW-1:0] SC_UP          = 8'h48;
  localparam logic [CodeW-1:0] SC_DOWN        = 8'h50;
  localparam logic [CodeW-1:0] SC_LEFT        = 8'h4B;
  localparam logic [CodeW-1:0] SC_RIGHT       = 8'h4D;
  localparam logic [CodeW-1:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [CodeW-1:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [CodeW-1:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [CodeW-1:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [CodeW-1:0] SC_CTRL_MAKE   = 8'h1D;
  localparam logic [CodeW-1:0] SC_CTRL_BRK    = 8'h9D;
  localparam logic [CodeW-1:0] SC_ALT_MAKE    = 8'h38;
  localparam logic [CodeW-1:0] SC_ALT_BRK     = 8'hB8;
  localparam logic [CodeW-1:0] SC_CAPS_MAKE   = 8'h3A;
  localparam logic [CodeW-1:0] SC_ENTER       = 8'h1C;
  localparam logic [CodeW-1:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [CodeW-1:0] SC_TAB         = 8'h0F;
  localparam logic [CodeW-1:0] SC_SPACE       = 8'h39;
  localparam logic [CodeW-1:0] SC_ESCAPE      = 8'h01;
  localparam logic [CodeW-1:0] SC_TABLE_END   = 8'h60;

  // characters produced for special keys
  localparam logic [CharW-1:0] CH_NONE  = 7'h00;
  localparam logic [CharW-1:0] CH_UP    = 7'h1E;
  localparam logic [CharW-1:0] CH_DOWN  = 7'h1F;
  localparam logic [CharW-1:0] CH_LEFT  = 7'h1A;
  localparam logic [CharW-1:0] CH_RIGHT = 7'h1B;
  localparam logic [CharW-1:0] CH_LF    = 7'h0A;
  localparam logic [CharW-1:0] CH_BS    = 7'h08;
  localparam logic [CharW-1:0] CH_TAB   = 7'h09;
  localparam logic [CharW-1:0] CH_SPACE = 7'h20;
  localparam logic [CharW-1:0] CH_ESC   = 7'h1B;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic ext;
  } scs1a_flags_t;

  // Lower / upper key table, 96 entries; unlisted entries give no character.
  function automatic logic [CharW-1:0] key_lut(input logic [6:0] idx, input logic upper);
    logic [CharW-1:0] lo;
    logic [CharW-1:0] up;
    lo = CH_NONE;
    up = CH_NONE;
    case (idx)
      7'h02: begin lo = 7'h31; up = 7'h21; end
      7'h03: begin lo = 7'h32; up = 7'h40; end
      7'h04: begin lo = 7'h33; up = 7'h23; end
      7'h05: begin lo = 7'h34; up = 7'h24; end
      7'h06: begin lo = 7'h35; up = 7'h25; end
      7'h07: begin lo = 7'h36; up = 7'h5E; end
      7'h08: begin lo = 7'h37; up = 7'h26; end
      7'h09: begin lo = 7'h38; up = 7'h2A; end
      7'h0A: begin lo = 7'h39; up = 7'h28; end
      7'h0B: begin lo = 7'h30; up = 7'h29; end
      7'h0C: begin lo = 7'h2D; up = 7'h5F; end
      7'h0D: begin lo = 7'h3D; up = 7'h2B; end
      7'h10: begin lo = 7'h71; up = 7'h51; end
      7'h11: begin lo = 7'h77; up = 7'h57; end
      7'h12: begin lo = 7'h65; up = 7'h45; end
      7'h13: begin lo = 7'h72; up = 7'h52; end
      7'h14: begin lo = 7'h74; up = 7'h54; end
      7'h15: begin lo = 7'h79; up = 7'h59; end
      7'h16: begin lo = 7'h75; up = 7'h55; end
      7'h17: begin lo = 7'h69; up = 7'h49; end
      7'h18: begin lo = 7'h6F; up = 7'h4F; end
      7'h19: begin lo = 7'h70; up = 7'h50; end
      7'h1A: begin lo = 7'h5B; up = 7'h7B; end
      7'h1B: begin lo = 7'h5D; up = 7'h7D; end
      7'h1C: begin lo = 7'h0A; up = 7'h0A; end
      7'h1E: begin lo = 7'h61; up = 7'h41; end
      7'h1F: begin lo = 7'h73; up = 7'h53; end
      7'h20: begin lo = 7'h64; up = 7'h44; end
      7'h21: begin lo = 7'h66; up = 7'h46; end
      7'h22: begin lo = 7'h67; up = 7'h47; end
      7'h23: begin lo = 7'h68; up = 7'h48; end
      7'h24: begin lo = 7'h6A; up = 7'h4A; end
      7'h25: begin lo = 7'h6B; up = 7'h4B; end
      7'h26: begin lo = 7'h6C; up = 7'h4C; end
      7'h27: begin lo = 7'h3B; up = 7'h3A; end
      7'h28: begin lo = 7'h27; up = 7'h22; end
      7'h29: begin lo = 7'h60; up = 7'h7E; end
      7'h2B: begin lo = 7'h5C; up = 7'h7C; end
      7'h2C: begin lo = 7'h7A; up = 7'h5A; end
      7'h2D: begin lo = 7'h78; up = 7'h58; end
      7'h2E: begin lo = 7'h63; up = 7'h43; end
      7'h2F: begin lo = 7'h76; up = 7'h56; end
      7'h30: begin lo = 7'h62; up = 7'h42; end
      7'h31: begin lo = 7'h6E; up = 7'h4E; end
      7'h32: begin lo = 7'h6D; up = 7'h4D; end
      7'h33: begin lo = 7'h2C; up = 7'h3C; end
      7'h34: begin lo = 7'h2E; up = 7'h3E; end
      7'h35: begin lo = 7'h2F; up = 7'h3F; end
      7'h37: begin lo = 7'h2A; up = 7'h2A; end
      7'h39: begin lo = 7'h20; up = 7'h20; end
      7'h47: begin lo = 7'h37; up = 7'h37; end
      7'h48: begin lo = 7'h38; up = 7'h38; end
      7'h49: begin lo = 7'h39; up = 7'h39; end
      7'h4A: begin lo = 7'h2D; up = 7'h2D; end
      7'h4B: begin lo = 7'h34; up = 7'h34; end
      7'h4C: begin lo = 7'h35; up = 7'h35; end
      7'h4D: begin lo = 7'h36; up = 7'h36; end
      7'h4E: begin lo = 7'h2B; up = 7'h2B; end
      7'h4F: begin lo = 7'h31; up = 7'h31; end
      7'h50: begin lo = 7'h32; up = 7'h32; end
      7'h51: begin lo = 7'h33; up = 7'h33; end
      7'h52: begin lo = 7'h30; up = 7'h30; end
      7'h53: begin lo = 7'h2E; up = 7'h2E; end
      default: begin lo = CH_NONE; up = CH_NONE; end
    endcase
    return upper ? up : lo;
  endfunction

endpackage

[hw/rtl/scs1a_decode.sv]
// ----------------------------------------------------------------------------
// scs1a_decode
// Combinational decode of one scancode against the current modifier flags.
// ----------------------------------------------------------------------------
module scs1a_decode import scs1a_pkg::*; (
  input  logic [CodeW-1:0] scancode,
  input  scs1a_flags_t     flags,
  output logic [CharW-1:0] character,
  output scs1a_flags_t     flags_next
);

  logic [CharW-1:0] lut_char;
  logic             is_lower;
  logic             is_upper;

  assign lut_char = key_lut(scancode[6:0], flags.shift);
  assign is_lower = (lut_char >= 7'h61) && (lut_char <= 7'h7A);
  assign is_upper = (lut_char >= 7'h41) && (lut_char <= 7'h5A);

  always_comb begin
    flags_next = flags;
    character  = CH_NONE;
    if (scancode == SC_PREFIX_E0) begin
      flags_next.ext = 1'b1;
    end else if (flags.ext) begin
      // byte after prefix: only arrows mean anything
      flags_next.ext = 1'b0;
      case (scancode)
        SC_UP:    character = CH_UP;
        SC_DOWN:  character = CH_DOWN;
        SC_LEFT:  character = CH_LEFT;
        SC_RIGHT: character = CH_RIGHT;
        default:  character = CH_NONE;
      endcase
    end else begin
      case (scancode)
        SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: flags_next.shift = 1'b1;
        SC_LSHIFT_BRK, SC_RSHIFT_BRK:   flags_next.shift = 1'b0;
        SC_CTRL_MAKE:                   flags_next.ctrl  = 1'b1;
        SC_CTRL_BRK:                    flags_next.ctrl  = 1'b0;
        SC_ALT_MAKE:                    flags_next.alt   = 1'b1;
        SC_ALT_BRK:                     flags_next.alt   = 1'b0;
        SC_CAPS_MAKE:                   flags_next.caps  = ~flags.caps;
        SC_ENTER:                       character = CH_LF;
        SC_BACKSPACE:                   character = CH_BS;
        SC_TAB:                         character = CH_TAB;
        SC_SPACE:                       character = CH_SPACE;
        SC_ESCAPE:                      character = CH_ESC;
        default: begin
          if (!scancode[7] && (scancode < SC_TABLE_END)) begin
            character = lut_char;
            // caps lock flips letter case; upper-case only flips under shift
            if (flags.caps && (is_lower || (is_upper && flags.shift))) begin
              character = lut_char ^ 7'h20;
            end
          end
        end
      endcase
    end
  end

endmodule

[hw/rtl/scancode_set1_to_ascii.sv]
// Set-1 scancode to ASCII decoder. One scancode byte in gives one result out:
// the character (0 when the byte produces none) and the shift, ctrl, alt and
// caps lock state after that byte. An item passes an input register and a
// result register before its result appears, and with the output side ready
// one item is taken every cycle; the only loop is the modifier flag update
// in the decode stage.
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// Top level: input register, decode with modifier flags, result register.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii import scs1a_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CodeW-1:0]    s_axis_tdata,   // [7:0] scancode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [6:0] character, [7] shift_held,
                                              // [8] ctrl_held, [9] alt_held,
                                              // [10] caps_on, [15:11] zero
);

  logic             in_valid;
  logic [CodeW-1:0] in_code;
  scs1a_flags_t     flags;
  scs1a_flags_t     flags_next;
  logic [CharW-1:0] dec_char;
  logic             out_valid;
  logic [CharW-1:0] out_char;
  scs1a_flags_t     out_flags;
  logic             advance;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_code <= s_axis_tdata;
    end
  end

  scs1a_decode u_decode (
    .scancode   (in_code),
    .flags      (flags),
    .character  (dec_char),
    .flags_next (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        flags <= flags_next;
      end
    end
    if (advance && in_valid) begin
      out_char  <= dec_char;
      out_flags <= flags_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_flags.caps, out_flags.alt, out_flags.ctrl,
                          out_flags.shift, out_char};

`ifndef SYNTH
  // flags only move when an item goes through decode
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && in_valid) |=> $stable(flags))
    else $error("modifier flags changed without an item");

  // a held input item is not dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_code)))
    else $error("input item lost under stall");

  // a printable result never leaves an extended prefix pending
  a_char_ext: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_char != CH_NONE)) |-> !flags.ext)
    else $error("character issued with prefix pending");

  // result flags mirror the live flags
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_flags == flags))
    else $error("result flags differ from state");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_valid))
    else $error("valid set after reset");
`endif

endmodule

[tb/sv/scancode_set1_to_ascii_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_tb
// Streams set-1 scancodes into the decoder and checks every result against a
// local keyboard-state predictor. The directed tests cover plain keys,
// modifiers, caps lock and the E0 prefix. The random part is mostly typing
// sequences, with bursty input, a stalling output side and one long output
// hold-off.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_tb;
  import scs1a_pkg::*;

  localparam logic [CodeW-1:0] BREAK_BIT = 8'h80;
  localparam int unsigned RX_HOLD_CYCLES = 200;

  // key tables, entry 0 in the leftmost byte
  localparam logic [0:95][7:0] LOWER_KEYS = {
    128'h0000_3132_3334_3536_3738_3930_2D3D_0000,
    128'h7177_6572_7479_7569_6F70_5B5D_0A00_6173,
    128'h6466_6768_6A6B_6C3B_2760_005C_7A78_6376,
    128'h626E_6D2C_2E2F_002A_0020_0000_0000_0000,
    128'h0000_0000_0000_0037_3839_2D34_3536_2B31,
    128'h3233_302E_0000_0000_0000_0000_0000_0000};
  localparam logic [0:95][7:0] UPPER_KEYS = {
    128'h0000_2140_2324_255E_262A_2829_5F2B_0000,
    128'h5157_4552_5459_5549_4F50_7B7D_0A00_4153,
    128'h4446_4748_4A4B_4C3A_227E_007C_5A58_4356,
    128'h424E_4D3C_3E3F_002A_0020_0000_0000_0000,
    128'h0000_0000_0000_0037_3839_2D34_3536_2B31,
    128'h3233_302E_0000_0000_0000_0000_0000_0000};
  localparam logic [0:3][CodeW-1:0] ARROW_KEYS = {SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT};

  typedef struct packed {
    logic [4:0]       spare;
    logic             caps;
    logic             alt;
    logic             ctrl;
    logic             shift;
    logic [CharW-1:0] ch;
  } key_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_THREE_IN_FOUR, RX_SPARSE} rx_mode_e;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [CodeW-1:0]    s_axis_tdata = '0;    // [7:0] scancode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [6:0] char, [7] shift, [8] ctrl,
                                             // [9] alt, [10] caps, [15:11] zero

  scs1a_flags_t  kbd = '0;
  key_result_t   decoded_q[$];
  int unsigned   items_sent = 0;
  int unsigned   results_seen = 0;
  int unsigned   mismatches = 0;
  int unsigned   burst_left = 0;
  logic          continuous = 1'b0;
  logic          rx_hold = 1'b0;
  logic          rx_hold_toggle = 1'b0;
  int unsigned   rx_tick = 0;
  rx_mode_e      rx_mode = RX_ALWAYS;

  scancode_set1_to_ascii i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // keyboard state predictor: updates kbd and returns the decoded result
  function automatic key_result_t decode_scancode(input logic [CodeW-1:0] code);
    key_result_t r;
    logic [CharW-1:0] c;
    c = CH_NONE;
    if (code == SC_PREFIX_E0) begin
      kbd.ext = 1'b1;
    end else if (kbd.ext) begin
      // only arrows mean anything after the prefix
      kbd.ext = 1'b0;
      case (code)
        SC_UP:    c = CH_UP;
        SC_DOWN:  c = CH_DOWN;
        SC_LEFT:  c = CH_LEFT;
        SC_RIGHT: c = CH_RIGHT;
        default:  c = CH_NONE;
      endcase
    end else if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
      kbd.shift = 1'b1;
    end else if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK) begin
      kbd.shift = 1'b0;
    end else if (code == SC_CTRL_MAKE) begin
      kbd.ctrl = 1'b1;
    end else if (code == SC_CTRL_BRK) begin
      kbd.ctrl = 1'b0;
    end else if (code == SC_ALT_MAKE) begin
      kbd.alt = 1'b1;
    end else if (code == SC_ALT_BRK) begin
      kbd.alt = 1'b0;
    end else if (code == SC_CAPS_MAKE) begin
      kbd.caps = !kbd.caps;
    end else if (code[7]) begin
      c = CH_NONE;
    end else if (code == SC_ENTER) begin
      c = CH_LF;
    end else if (code == SC_BACKSPACE) begin
      c = CH_BS;
    end else if (code == SC_TAB) begin
      c = CH_TAB;
    end else if (code == SC_SPACE) begin
      c = CH_SPACE;
    end else if (code == SC_ESCAPE) begin
      c = CH_ESC;
    end else if (code < SC_TABLE_END) begin
      c = kbd.shift ? UPPER_KEYS[code[6:0]][6:0] : LOWER_KEYS[code[6:0]][6:0];
      // caps flips letter case only
      if (kbd.caps) begin
        if (c >= 7'h61 && c <= 7'h7A) begin
          c = c - 7'h20;
        end else if (c >= 7'h41 && c <= 7'h5A && kbd.shift) begin
          c = c + 7'h20;
        end
      end
    end
    r.spare = '0;
    r.caps  = kbd.caps;
    r.alt   = kbd.alt;
    r.ctrl  = kbd.ctrl;
    r.shift = kbd.shift;
    r.ch    = c;
    return r;
  endfunction

  // sends one scancode, with bursts and random gaps unless continuous
  task automatic send_code(input logic [CodeW-1:0] code);
    int unsigned gap;
    if (burst_left == 0 && !continuous) begin
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        5:       gap = $urandom_range(5, 20);
        default: gap = $urandom_range(1, 4);
      endcase
      repeat (gap) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk); while (!s_axis_tready);
    decoded_q.push_back(decode_scancode(code));
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_keystroke(input logic [CodeW-1:0] code);
    send_code(code);
    send_code(code | BREAK_BIT);
  endtask

  // input idle until every outstanding result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  task automatic test_plain_keys();
    send_code(8'h00);
    send_code(8'hFF);
    send_code(SC_ESCAPE);
    send_code(SC_BACKSPACE);
    send_code(SC_TAB);
    send_code(SC_ENTER);
    send_code(SC_SPACE);
    send_code(8'h7F);        // make code past the table
  endtask

  task automatic test_modifier_keys();
    send_code(SC_LSHIFT_MAKE);
    send_code(SC_CAPS_MAKE);
    send_code(8'h1E);        // shift and caps together give lower case
    send_code(8'h02);
    send_code(SC_RSHIFT_BRK);
    send_code(8'h1E);
    send_code(SC_CAPS_MAKE | BREAK_BIT);  // caps break is ignored
    send_code(SC_CTRL_MAKE);
    send_code(SC_CTRL_BRK);
    send_code(SC_ALT_MAKE);
    send_code(SC_ALT_BRK);
  endtask

  task automatic test_extended_prefix();
    send_code(SC_PREFIX_E0);
    send_code(SC_UP);
    send_code(SC_PREFIX_E0);
    send_code(SC_PREFIX_E0);  // prefix repeated
    send_code(SC_DOWN);
    send_code(SC_PREFIX_E0);
    send_code(SC_LEFT);
    send_code(SC_PREFIX_E0);
    send_code(SC_RIGHT);
    send_code(SC_PREFIX_E0);
    send_code(SC_LSHIFT_MAKE); // modifier behind prefix changes nothing
  endtask

  // long output stall while input keeps coming, so the block backs up
  task automatic test_output_hold_off();
    rx_hold_toggle <= !rx_hold_toggle;
    continuous = 1'b1;
    repeat (40) send_keystroke(8'($urandom_range(1, 8'h5F)));
    continuous = 1'b0;
  endtask

  task automatic test_random_typing(input int unsigned target);
    int unsigned stop_at;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] modifier;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_keystroke(8'($urandom_range(1, 8'h5F)));
        3: begin
          send_code($urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
          repeat ($urandom_range(1, 4)) send_keystroke(8'($urandom_range(1, 8'h5F)));
          send_code($urandom_range(0, 1) ? SC_LSHIFT_BRK : SC_RSHIFT_BRK);
        end
        4: begin
          code = ($urandom_range(0, 3) != 0) ? ARROW_KEYS[2'($urandom_range(0, 3))]
                                             : 8'($urandom_range(0, 255));
          send_code(SC_PREFIX_E0);
          send_code(code);
          send_code(SC_PREFIX_E0);
          send_code(code | BREAK_BIT);
        end
        5: send_keystroke(SC_CAPS_MAKE);
        6: begin
          modifier = $urandom_range(0, 1) ? SC_CTRL_MAKE : SC_ALT_MAKE;
          send_code(modifier);
          send_keystroke(8'($urandom_range(1, 8'h5F)));
          send_code(modifier | BREAK_BIT);
        end
        default: send_code(8'($urandom_range(0, 255)));  // noise
      endcase
    end
  endtask

  // output side: stall pattern is picked anew whenever rx_tick[6:0] is zero
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick[6:0] == 7'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:        m_axis_tready <= !rx_hold;
      RX_RANDOM:        m_axis_tready <= !rx_hold && ($urandom_range(0, 1) == 1);
      RX_THREE_IN_FOUR: m_axis_tready <= !rx_hold && (rx_tick[1:0] != 2'd0);
      default:          m_axis_tready <= !rx_hold && ($urandom_range(0, 4) == 0);
    endcase
  end

  initial begin
    logic hold_seen;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_toggle != hold_seen) begin
        hold_seen = rx_hold_toggle;
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = key_result_t'(m_axis_tdata);
      results_seen++;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %h", results_seen, got);
      end else begin
        want = decoded_q.pop_front();
        if (got.ch !== want.ch || got.shift !== want.shift || got.ctrl !== want.ctrl ||
            got.alt !== want.alt || got.caps !== want.caps || got.spare !== want.spare) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected ch=%h sh=%b ct=%b al=%b cp=%b sp=%h,",
                     results_seen, want.ch, want.shift, want.ctrl, want.alt, want.caps,
                     want.spare,
                     " got ch=%h sh=%b ct=%b al=%b cp=%b sp=%h",
                     got.ch, got.shift, got.ctrl, got.alt, got.caps, got.spare);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("scancode_set1_to_ascii_tb: errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_plain_keys();
    wait_drained();
    test_modifier_keys();
    wait_drained();
    test_extended_prefix();
    wait_drained();
    test_output_hold_off();
    wait_drained();
    test_random_typing(1350);
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("scancode_set1_to_ascii_tb: clean");
    end else begin
      $display("scancode_set1_to_ascii_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/scs1a_pkg.sv
hw/rtl/scs1a_decode.sv
hw/rtl/scancode_set1_to_ascii.sv
tb/sv/scancode_set1_to_ascii_tb.sv
